>>> hw/rtl/hdt_pkg.sv
package hdt_pkg;

  // Parse states of the DOCTYPE walk.
  typedef enum logic [3:0] {
    ST_IDLE        = 4'd0,
    ST_BEFORE_NAME = 4'd1,
    ST_NAME        = 4'd2,
    ST_AFTER_NAME  = 4'd3,
    ST_KEYWORD     = 4'd4,
    ST_BEFORE_PUB  = 4'd5,
    ST_PUB_ID      = 4'd6,
    ST_AFTER_PUB   = 4'd7,
    ST_SYS_ID      = 4'd8,
    ST_AFTER_SYS   = 4'd9,
    ST_BOGUS       = 4'd10
  } hdt_state_t;

  // Span kinds carried on the result channel.
  localparam logic [2:0] KIND_NAME   = 3'd0;
  localparam logic [2:0] KIND_PUBLIC = 3'd1;
  localparam logic [2:0] KIND_SYSTEM = 3'd2;
  localparam logic [2:0] KIND_PUB_ID = 3'd3;
  localparam logic [2:0] KIND_SYS_ID = 3'd4;
  localparam logic [2:0] KIND_END    = 3'd5;

  // Request actions.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  localparam logic [7:0]  CH_GT     = 8'h3E;
  localparam logic [7:0]  CH_DQUOTE = 8'h22;
  localparam logic [7:0]  CH_SQUOTE = 8'h27;
  localparam logic [2:0]  KW_LEN    = 3'd6;
  localparam logic [31:0] KW_SPAN   = 32'd6;

  // Default depth of the result queue.
  localparam int HDT_QDEPTH = 4;

  typedef struct packed {
    logic        action;
    logic [7:0]  ch;
    logic [31:0] position;
  } hdt_in_t;

  typedef struct packed {
    logic [2:0]  span_kind;
    logic [31:0] span_begin;
    logic [31:0] span_length;
    logic        quirks;
    logic        last;
  } hdt_out_t;

  // Token context kept between bytes.
  typedef struct packed {
    logic [31:0] token_begin;
    logic [31:0] span_start;
    logic [2:0]  kw_index;
    logic [1:0]  kw_match;
    logic        close_single;
    logic        quirks_seen;
  } hdt_ctx_t;

  // Results produced by one request: up to two, in order.
  typedef struct packed {
    logic [1:0] cnt;
    hdt_out_t   r0;
    hdt_out_t   r1;
  } hdt_res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

  // Keyword letters; sys selects SYSTEM over PUBLIC.
  function automatic logic [7:0] kw_char(input logic sys, input logic [2:0] i);
    logic [7:0] ch;
    unique case (i)
      3'd0: ch = sys ? 8'h53 : 8'h50;
      3'd1: ch = sys ? 8'h59 : 8'h55;
      3'd2: ch = sys ? 8'h53 : 8'h42;
      3'd3: ch = sys ? 8'h54 : 8'h4C;
      3'd4: ch = sys ? 8'h45 : 8'h49;
      3'd5: ch = sys ? 8'h4D : 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic hdt_out_t mk_span(input logic [2:0] kind, input logic [31:0] sbeg,
                                       input logic [31:0] slen, input logic q);
    hdt_out_t o;
    o.span_kind   = kind;
    o.span_begin  = sbeg;
    o.span_length = slen;
    o.quirks      = q;
    o.last        = 1'b0;
    return o;
  endfunction

endpackage

>>> hw/rtl/hdt_step.sv
module hdt_step
  import hdt_pkg::*;
(
  input  hdt_state_t state_r,
  input  hdt_ctx_t   ctx_r,
  input  hdt_in_t    in_data,
  output hdt_state_t state_nxt,
  output hdt_ctx_t   ctx_nxt,
  output hdt_res_t   res
);

  logic [7:0]  c;
  logic [31:0] pos;
  logic        sp;
  logic        gt;
  logic        quote;
  logic        quote_close;
  logic [7:0]  upper;
  logic [2:0]  kw_idx_e;
  logic [1:0]  kw_match_e;
  logic [31:0] span_start_e;
  logic        pub_miss;
  logic        sys_miss;
  logic [1:0]  m_nxt;
  logic        kw_fail;
  logic [2:0]  idx_n;
  logic        kw_done;
  logic [31:0] span_len;
  logic [31:0] end_len;
  logic        id_nonempty;
  hdt_state_t  kw_state;

  // Byte classes.
  assign c           = in_data.ch;
  assign pos         = in_data.position;
  assign sp          = is_space(c);
  assign gt          = (c == CH_GT);
  assign quote       = is_quote(c);
  assign quote_close = (c == (ctx_r.close_single ? CH_SQUOTE : CH_DQUOTE));

  // Keyword matcher; the first non-space byte after the name restarts it.
  assign upper        = ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
  assign kw_idx_e     = (state_r == ST_AFTER_NAME) ? 3'd0 : ctx_r.kw_index;
  assign kw_match_e   = (state_r == ST_AFTER_NAME) ? 2'b11 : ctx_r.kw_match;
  assign span_start_e = (state_r == ST_AFTER_NAME) ? pos : ctx_r.span_start;
  assign pub_miss     = (kw_idx_e >= KW_LEN) || (upper != kw_char(1'b0, kw_idx_e));
  assign sys_miss     = (kw_idx_e >= KW_LEN) || (upper != kw_char(1'b1, kw_idx_e));
  assign m_nxt        = kw_match_e & {~sys_miss, ~pub_miss};
  assign kw_fail      = (m_nxt == 2'b00);
  assign idx_n        = kw_idx_e + 3'd1;
  assign kw_done      = (idx_n >= KW_LEN);

  // Span lengths.
  assign span_len    = pos - ctx_r.span_start;
  assign end_len     = pos + 32'd1 - ctx_r.token_begin;
  assign id_nonempty = (ctx_r.span_start < pos);

  always_comb begin
    if (kw_fail) begin
      kw_state = gt ? ST_IDLE : ST_BOGUS;
    end else if (kw_done) begin
      kw_state = m_nxt[0] ? ST_BEFORE_PUB : ST_AFTER_PUB;
    end else begin
      kw_state = ST_KEYWORD;
    end
  end

  // Next parse state.
  always_comb begin
    state_nxt = state_r;
    if (in_data.action == ACT_START) begin
      state_nxt = ST_BEFORE_NAME;
    end else begin
      unique case (state_r)
        ST_IDLE:        state_nxt = ST_IDLE;
        ST_BEFORE_NAME: state_nxt = sp ? ST_BEFORE_NAME : (gt ? ST_IDLE : ST_NAME);
        ST_NAME:        state_nxt = gt ? ST_IDLE : (sp ? ST_AFTER_NAME : ST_NAME);
        ST_AFTER_NAME:  state_nxt = sp ? ST_AFTER_NAME : (gt ? ST_IDLE : kw_state);
        ST_KEYWORD:     state_nxt = kw_state;
        ST_BEFORE_PUB: begin
          if (sp)         state_nxt = ST_BEFORE_PUB;
          else if (quote) state_nxt = ST_PUB_ID;
          else if (gt)    state_nxt = ST_IDLE;
          else            state_nxt = ST_BOGUS;
        end
        ST_PUB_ID:      state_nxt = quote_close ? ST_AFTER_PUB : (gt ? ST_IDLE : ST_PUB_ID);
        ST_AFTER_PUB: begin
          if (sp)         state_nxt = ST_AFTER_PUB;
          else if (quote) state_nxt = ST_SYS_ID;
          else if (gt)    state_nxt = ST_IDLE;
          else            state_nxt = ST_BOGUS;
        end
        ST_SYS_ID:      state_nxt = quote_close ? ST_AFTER_SYS : (gt ? ST_IDLE : ST_SYS_ID);
        ST_AFTER_SYS:   state_nxt = sp ? ST_AFTER_SYS : (gt ? ST_IDLE : ST_BOGUS);
        ST_BOGUS:       state_nxt = gt ? ST_IDLE : ST_BOGUS;
        default:        state_nxt = ST_IDLE;
      endcase
    end
  end

  // Context update and emitted spans.
  always_comb begin
    ctx_nxt = ctx_r;
    res     = '0;
    if (in_data.action == ACT_START) begin
      ctx_nxt.token_begin  = pos;
      ctx_nxt.span_start   = '0;
      ctx_nxt.kw_index     = '0;
      ctx_nxt.kw_match     = 2'b11;
      ctx_nxt.close_single = 1'b0;
      ctx_nxt.quirks_seen  = 1'b0;
    end else begin
      unique case (state_r)
        ST_BEFORE_NAME: begin
          if (!sp) begin
            if (gt) begin
              ctx_nxt.quirks_seen = 1'b1;
              res.r0  = mk_span(KIND_END, ctx_r.token_begin, end_len, 1'b1);
              res.cnt = 2'd1;
            end else begin
              ctx_nxt.span_start = pos;
            end
          end
        end
        ST_NAME: begin
          if (gt) begin
            res.r0  = mk_span(KIND_NAME, ctx_r.span_start, span_len, 1'b0);
            res.r1  = mk_span(KIND_END, ctx_r.token_begin, end_len, ctx_r.quirks_seen);
            res.cnt = 2'd2;
          end else if (sp) begin
            res.r0  = mk_span(KIND_NAME, ctx_r.span_start, span_len, 1'b0);
            res.cnt = 2'd1;
          end
        end
        ST_AFTER_NAME, ST_KEYWORD: begin
          if ((state_r == ST_AFTER_NAME) && sp) begin
            res.cnt = 2'd0;
          end else if ((state_r == ST_AFTER_NAME) && gt) begin
            res.r0  = mk_span(KIND_END, ctx_r.token_begin, end_len, ctx_r.quirks_seen);
            res.cnt = 2'd1;
          end else begin
            ctx_nxt.span_start = span_start_e;
            ctx_nxt.kw_match   = m_nxt;
            ctx_nxt.kw_index   = kw_idx_e;
            if (kw_fail) begin
              // Mismatching byte is treated as a bogus-state byte.
              ctx_nxt.quirks_seen = 1'b1;
              if (gt) begin
                res.r0  = mk_span(KIND_END, ctx_r.token_begin, end_len, 1'b1);
                res.cnt = 2'd1;
              end
            end else begin
              ctx_nxt.kw_index = idx_n;
              if (kw_done) begin
                res.r0  = mk_span(m_nxt[0] ? KIND_PUBLIC : KIND_SYSTEM, span_start_e,
                                  KW_SPAN, 1'b0);
                res.cnt = 2'd1;
              end
            end
          end
        end
        ST_BEFORE_PUB, ST_AFTER_PUB: begin
          if (!sp) begin
            if (quote) begin
              ctx_nxt.span_start   = pos + 32'd1;
              ctx_nxt.close_single = (c == CH_SQUOTE);
            end else if (gt) begin
              // A missing public identifier forces quirks.
              ctx_nxt.quirks_seen = (state_r == ST_BEFORE_PUB) | ctx_r.quirks_seen;
              res.r0  = mk_span(KIND_END, ctx_r.token_begin, end_len,
                                (state_r == ST_BEFORE_PUB) | ctx_r.quirks_seen);
              res.cnt = 2'd1;
            end else begin
              ctx_nxt.quirks_seen = 1'b1;
            end
          end
        end
        ST_PUB_ID, ST_SYS_ID: begin
          if (quote_close) begin
            res.r0  = mk_span((state_r == ST_PUB_ID) ? KIND_PUB_ID : KIND_SYS_ID,
                              ctx_r.span_start, span_len, 1'b0);
            res.cnt = 2'd1;
          end else if (gt) begin
            // Unterminated identifier: the span only if it holds bytes, then the end.
            ctx_nxt.quirks_seen = 1'b1;
            if (id_nonempty) begin
              res.r0  = mk_span((state_r == ST_PUB_ID) ? KIND_PUB_ID : KIND_SYS_ID,
                                ctx_r.span_start, span_len, 1'b0);
              res.r1  = mk_span(KIND_END, ctx_r.token_begin, end_len, 1'b1);
              res.cnt = 2'd2;
            end else begin
              res.r0  = mk_span(KIND_END, ctx_r.token_begin, end_len, 1'b1);
              res.cnt = 2'd1;
            end
          end
        end
        ST_AFTER_SYS, ST_BOGUS: begin
          if (gt) begin
            res.r0  = mk_span(KIND_END, ctx_r.token_begin, end_len, ctx_r.quirks_seen);
            res.cnt = 2'd1;
          end
        end
        default: begin
          res.cnt = 2'd0;
        end
      endcase
    end

    // Mark the final span of this request.
    if (res.cnt == 2'd1) begin
      res.r0.last = 1'b1;
    end else if (res.cnt == 2'd2) begin
      res.r1.last = 1'b1;
    end
  end

endmodule

>>> hw/rtl/hdt_outq.sv
module hdt_outq
  import hdt_pkg::*;
#(
  parameter int DEPTH = HDT_QDEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  hdt_out_t   push0,
  input  hdt_out_t   push1,
  input  logic       pop,
  output hdt_out_t   head,
  output logic       not_empty,
  output logic       room2
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hdt_out_t        mem [DEPTH];
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   rd_r;
  logic [CW-1:0]   cnt_r;
  logic [PW-1:0]   wr1;
  logic [PW-1:0]   wr_nxt;
  logic [PW-1:0]   rd_nxt;
  logic [CW-1:0]   cnt_nxt;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Pointer arithmetic.
  assign wr1     = wrap_inc(wr_r);
  assign wr_nxt  = (push_cnt == 2'd2) ? wrap_inc(wr1) : ((push_cnt == 2'd1) ? wr1 : wr_r);
  assign rd_nxt  = pop ? wrap_inc(rd_r) : rd_r;
  assign cnt_nxt = cnt_r + CW'(push_cnt) - CW'(pop);

  assign head      = mem[rd_r];
  assign not_empty = (cnt_r != '0);
  assign room2     = (cnt_r <= CW'(DEPTH - 2));

  // Result storage.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr1] <= push1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // The fill level never passes the depth.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(DEPTH))
    else $error("result queue overfilled");

  // A pop only happens with something stored.
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> cnt_r != '0)
    else $error("result queue popped while empty");

  // Pushes only land when room was reported.
  assert property (@(posedge clk) disable iff (!rst_n) (push_cnt != 2'd0) |-> room2)
    else $error("result queue pushed without room");

endmodule

>>> hw/rtl/html_doctype_tokenizer_unit.sv
// Channel  Direction  Payload    Handshake
// in_      input      hdt_in_t   in_valid / in_stall (stall driven by this block)
// out_     output     hdt_out_t  out_valid / out_stall (stall driven by the sink)
//
// One request is taken per cycle while in_stall is low; its spans appear in the result queue the next cycle.
// A request yields zero, one or two spans, and the queue drains one span per cycle while out_stall is low.
// in_stall rises when the queue has fewer than two free entries.
// Synchronous active-low reset returns the parser to idle and empties the queue.
// out_stall holds the head span in place while further requests keep arriving, as long as in_stall stays low.
module html_doctype_tokenizer_unit
  import hdt_pkg::*;
#(
  parameter int QUEUE_DEPTH = HDT_QDEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hdt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hdt_out_t out_data
);

  hdt_state_t state_r;
  hdt_state_t state_nxt;
  hdt_ctx_t   ctx_r;
  hdt_ctx_t   ctx_nxt;
  hdt_res_t   res;
  logic       in_acc;
  logic       out_acc;
  logic       room2;
  logic [1:0] push_cnt;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = !room2;
  assign push_cnt = in_acc ? res.cnt : 2'd0;

  // Per-request state transition.
  hdt_step u_step (
    .state_r   (state_r),
    .ctx_r     (ctx_r),
    .in_data   (in_data),
    .state_nxt (state_nxt),
    .ctx_nxt   (ctx_nxt),
    .res       (res)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ctx_r   <= '{token_begin: '0, span_start: '0, kw_index: '0, kw_match: 2'b11,
                   close_single: 1'b0, quirks_seen: 1'b0};
    end else if (in_acc) begin
      state_r <= state_nxt;
      ctx_r   <= ctx_nxt;
    end
  end

  // Result queue between the parser and the output channel.
  hdt_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res.r0),
    .push1     (res.r1),
    .pop       (out_acc),
    .head      (out_data),
    .not_empty (out_valid),
    .room2     (room2)
  );

  // A start request always leaves the parser waiting for the name.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_acc && (in_data.action == ACT_START)) |=> state_r == ST_BEFORE_NAME)
    else $error("start request did not open a token");

  // A token end is always the final span of its request.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && (out_data.span_kind == KIND_END)) |-> out_data.last)
    else $error("token end span without last");

  // Only the token end carries the quirks flag.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && (out_data.span_kind != KIND_END)) |-> !out_data.quirks)
    else $error("quirks flag on a non-end span");

  // Spans leave the parser only when it returns to idle or stays in a token.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_acc && (state_r == ST_IDLE)) |-> push_cnt == 2'd0)
    else $error("span emitted outside a token");

endmodule

>>> bench/html_doctype_tokenizer_unit_tb.sv
module html_doctype_tokenizer_unit_tb;
  import hdt_pkg::*;

  localparam int          ITEM_TARGET  = 850;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          DRAIN_CYCLES = 20;
  localparam logic [47:0] WORD_PUBLIC  = "PUBLIC";
  localparam logic [47:0] WORD_SYSTEM  = "SYSTEM";

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  hdt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hdt_out_t out_data;

  // Span predictor state, mirrored from the DOCTYPE walk.
  hdt_state_t  tok_state = ST_IDLE;
  logic [31:0] tok_begin = '0;
  logic [31:0] span_mark = '0;
  logic [2:0]  kw_pos = '0;
  logic [1:0]  kw_alive = 2'b11;
  logic        quote_single = 1'b0;
  logic        quirk_flag = 1'b0;

  hdt_out_t    step_spans[$];
  hdt_out_t    pending_spans[$];
  hdt_out_t    want;

  int          items_sent = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  logic [31:0] stream_pos = '0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_count = 0;

  html_doctype_tokenizer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic blank_byte(input logic [7:0] c);
    return c inside {8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20};
  endfunction

  function automatic logic quote_byte(input logic [7:0] c);
    return (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

  function automatic logic [7:0] word_letter(input logic [47:0] word, input int i);
    return word[8*(5-i) +: 8];
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  // ---------------------------------------------------------------------------
  // Span predictor
  // ---------------------------------------------------------------------------

  task automatic add_span(input logic [2:0] kind, input logic [31:0] sbeg,
                          input logic [31:0] slen, input logic q);
    hdt_out_t s;
    s.span_kind   = kind;
    s.span_begin  = sbeg;
    s.span_length = slen;
    s.quirks      = q;
    s.last        = 1'b0;
    step_spans.push_back(s);
  endtask

  // The token-end span covers everything up to and including the '>'.
  task automatic close_token(input logic [31:0] p);
    add_span(KIND_END, tok_begin, p + 32'd1 - tok_begin, quirk_flag);
    tok_state = ST_IDLE;
  endtask

  task automatic quoted_byte(input logic [7:0] c, input logic [31:0] p,
                             input logic [2:0] kind, input hdt_state_t next);
    if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
      add_span(kind, span_mark, p - span_mark, 1'b0);
      tok_state = next;
    end else if (c == CH_GT) begin
      // An unterminated identifier is only reported when it holds bytes.
      quirk_flag = 1'b1;
      if (span_mark < p) add_span(kind, span_mark, p - span_mark, 1'b0);
      close_token(p);
    end
  endtask

  task automatic predict_spans(input hdt_in_t req);
    logic [7:0]  c;
    logic [31:0] p;
    logic        kw_step;
    c = req.ch;
    p = req.position;
    kw_step = 1'b0;
    step_spans.delete();

    // A start request opens a fresh token and drops any open one silently.
    if (req.action == ACT_START) begin
      tok_begin    = p;
      span_mark    = '0;
      kw_pos       = '0;
      kw_alive     = 2'b11;
      quote_single = 1'b0;
      quirk_flag   = 1'b0;
      tok_state    = ST_BEFORE_NAME;
      return;
    end

    case (tok_state)
      ST_BEFORE_NAME: begin
        if (c == CH_GT) begin
          quirk_flag = 1'b1;
          close_token(p);
        end else if (!blank_byte(c)) begin
          span_mark = p;
          tok_state = ST_NAME;
        end
      end
      ST_NAME: begin
        if (c == CH_GT) begin
          add_span(KIND_NAME, span_mark, p - span_mark, 1'b0);
          close_token(p);
        end else if (blank_byte(c)) begin
          add_span(KIND_NAME, span_mark, p - span_mark, 1'b0);
          tok_state = ST_AFTER_NAME;
        end
      end
      ST_AFTER_NAME: begin
        if (c == CH_GT) begin
          close_token(p);
        end else if (!blank_byte(c)) begin
          span_mark = p;
          kw_pos    = '0;
          kw_alive  = 2'b11;
          tok_state = ST_KEYWORD;
          kw_step   = 1'b1;
        end
      end
      ST_KEYWORD: kw_step = 1'b1;
      ST_BEFORE_PUB: begin
        if (quote_byte(c)) begin
          span_mark    = p + 32'd1;
          quote_single = (c == CH_SQUOTE);
          tok_state    = ST_PUB_ID;
        end else if (c == CH_GT) begin
          quirk_flag = 1'b1;
          close_token(p);
        end else if (!blank_byte(c)) begin
          quirk_flag = 1'b1;
          tok_state  = ST_BOGUS;
        end
      end
      ST_PUB_ID: quoted_byte(c, p, KIND_PUB_ID, ST_AFTER_PUB);
      ST_AFTER_PUB: begin
        if (quote_byte(c)) begin
          span_mark    = p + 32'd1;
          quote_single = (c == CH_SQUOTE);
          tok_state    = ST_SYS_ID;
        end else if (c == CH_GT) begin
          close_token(p);
        end else if (!blank_byte(c)) begin
          quirk_flag = 1'b1;
          tok_state  = ST_BOGUS;
        end
      end
      ST_SYS_ID: quoted_byte(c, p, KIND_SYS_ID, ST_AFTER_SYS);
      ST_AFTER_SYS: begin
        if (c == CH_GT) close_token(p);
        else if (!blank_byte(c)) tok_state = ST_BOGUS;
      end
      ST_BOGUS: begin
        if (c == CH_GT) close_token(p);
      end
      default: tok_state = ST_IDLE;
    endcase

    // Keyword match, case-insensitive, one letter per byte.
    if (kw_step) begin
      if (kw_pos >= KW_LEN) begin
        kw_alive = 2'b00;
      end else begin
        if (upcase(c) != word_letter(WORD_PUBLIC, kw_pos)) kw_alive[0] = 1'b0;
        if (upcase(c) != word_letter(WORD_SYSTEM, kw_pos)) kw_alive[1] = 1'b0;
      end
      if (kw_alive == 2'b00) begin
        quirk_flag = 1'b1;
        tok_state  = ST_BOGUS;
        if (c == CH_GT) close_token(p);
      end else begin
        kw_pos = kw_pos + 3'd1;
        if (kw_pos >= KW_LEN) begin
          if (kw_alive[0]) begin
            add_span(KIND_PUBLIC, span_mark, KW_SPAN, 1'b0);
            tok_state = ST_BEFORE_PUB;
          end else begin
            add_span(KIND_SYSTEM, span_mark, KW_SPAN, 1'b0);
            tok_state = ST_AFTER_PUB;
          end
        end
      end
    end

    if (step_spans.size() != 0) step_spans[step_spans.size()-1].last = 1'b1;
    foreach (step_spans[i]) pending_spans.push_back(step_spans[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Sends one request; the sender runs in bursts with random gaps between them.
  task automatic send_request(input logic act, input logic [7:0] c, input logic [31:0] p);
    hdt_in_t req;
    req.action   = act;
    req.ch       = c;
    req.position = p;
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_START || tok_state != ST_IDLE) items_sent++;
    predict_spans(req);
  endtask

  task automatic put_byte(input logic [7:0] c);
    send_request(ACT_BYTE, c, stream_pos);
    stream_pos = stream_pos + 32'd1;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_blanks(input int n);
    logic [7:0] blanks [5];
    blanks = '{8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20};
    repeat (n) put_byte(blanks[$urandom_range(0, 4)]);
  endtask

  // Random byte, never '>', with optional exclusions.
  function automatic logic [7:0] pick_byte(input bit blank_ok, input bit quote_ok,
                                           input logic [7:0] banned);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_GT || c == banned || (!blank_ok && blank_byte(c)) ||
           (!quote_ok && quote_byte(c)));
    return c;
  endfunction

  function automatic logic [7:0] mixed_case(input logic [7:0] letter);
    return letter | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
  endfunction

  task automatic bogus_tail();
    repeat ($urandom_range(0, 3)) put_byte(pick_byte(1'b1, 1'b1, CH_GT));
    put_byte(CH_GT);
  endtask

  // Quoted identifier with random content; ended tells whether '>' closed the token.
  task automatic quoted_id(output bit ended);
    logic [7:0] q;
    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    put_byte(q);
    repeat ($urandom_range(0, 5)) put_byte(pick_byte(1'b1, 1'b1, q));
    ended = ($urandom_range(0, 99) < 15);
    put_byte(ended ? CH_GT : q);
  endtask

  // One DOCTYPE token, mostly well formed, with random early exits and breakage.
  task automatic random_token();
    int          pick;
    int          k;
    bit          ended;
    logic [7:0]  c;
    logic [31:0] start;
    logic [47:0] word;
    start = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
    send_request(ACT_START, 8'($urandom_range(0, 255)), start);
    stream_pos = start + $urandom_range(1, 9);

    put_blanks($urandom_range(0, 2));
    if ($urandom_range(0, 99) < 8) begin
      put_byte(CH_GT);
      return;
    end
    repeat ($urandom_range(1, 6)) put_byte(pick_byte(1'b0, 1'b1, CH_GT));
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      put_byte(CH_GT);
      return;
    end
    // Abandoned token: the next start request drops it.
    if (pick < 14) return;
    put_blanks($urandom_range(1, 2));
    if ($urandom_range(0, 99) < 6) begin
      put_byte(CH_GT);
      return;
    end

    pick = $urandom_range(0, 99);
    word = (pick >= 57) ? WORD_SYSTEM : WORD_PUBLIC;
    if (pick < 15) begin
      // Keyword that breaks off after a random number of letters.
      k = $urandom_range(0, 5);
      for (int i = 0; i < k; i++) put_byte(mixed_case(word_letter(word, i)));
      if ($urandom_range(0, 3) == 0) begin
        put_byte(CH_GT);
        return;
      end
      do c = pick_byte(k != 0, 1'b1, CH_GT);
      while (upcase(c) == word_letter(WORD_PUBLIC, k) ||
             upcase(c) == word_letter(WORD_SYSTEM, k));
      put_byte(c);
      bogus_tail();
      return;
    end
    for (int i = 0; i < 6; i++) put_byte(mixed_case(word_letter(word, i)));

    if (word == WORD_PUBLIC) begin
      put_blanks($urandom_range(0, 2));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        put_byte(CH_GT);
        return;
      end
      if (pick < 16) begin
        put_byte(pick_byte(1'b0, 1'b0, CH_GT));
        bogus_tail();
        return;
      end
      quoted_id(ended);
      if (ended) return;
    end

    put_blanks($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      put_byte(CH_GT);
      return;
    end
    if (pick < 32) begin
      put_byte(pick_byte(1'b0, 1'b0, CH_GT));
      bogus_tail();
      return;
    end
    quoted_id(ended);
    if (ended) return;

    put_blanks($urandom_range(0, 2));
    if ($urandom_range(0, 99) < 80) begin
      put_byte(CH_GT);
    end else begin
      put_byte(pick_byte(1'b0, 1'b1, CH_GT));
      bogus_tail();
    end
  endtask

  // Holds the sender off until every predicted span has been seen.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A byte outside a token is ignored; a '>' before the name ends a token
  // whose length wraps past the top of the position range.
  task automatic test_idle_and_wrap();
    send_request(ACT_BYTE, 8'hFF, 32'h0000_0000);
    send_request(ACT_START, 8'h00, 32'hFFFF_FFFE);
    send_request(ACT_BYTE, 8'h20, 32'hFFFF_FFFF);
    send_request(ACT_BYTE, CH_GT, 32'h0000_0000);
  endtask

  // Name closed directly by '>' gives a name span and a token end together.
  task automatic test_name_then_end();
    send_request(ACT_START, 8'hFF, 32'd100);
    stream_pos = 32'd109;
    put_text("a>");
  endtask

  // Mixed-case PUBLIC, then an empty quoted identifier cut off by '>'.
  task automatic test_public_empty_id();
    send_request(ACT_START, 8'h00, 32'h8000_0000);
    stream_pos = 32'h8000_0009;
    put_text("h PuBlIc'>");
  endtask

  // A start inside an open token, then a keyword that fails on '>'.
  task automatic test_restart_and_bad_keyword();
    send_request(ACT_START, 8'h00, 32'd300);
    send_request(ACT_START, 8'h00, 32'd400);
    stream_pos = 32'd409;
    put_text("z s>");
  endtask

  task automatic test_drain_pause();
    wait_drained();
  endtask

  task automatic test_random_tokens();
    while (items_sent < ITEM_TARGET) begin
      // Noise: random requests, mostly ignored outside a token.
      if ($urandom_range(0, 99) < 8)
        repeat ($urandom_range(1, 3))
          send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom);
      random_token();
      if ($urandom_range(0, 99) < 4) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver stall pattern, switching at random between modes.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_count == 0) begin
        stall_mode  = stall_mode_t'($urandom_range(0, 3));
        stall_count = $urandom_range(16, 96);
      end else begin
        stall_count--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= cycle_count[2];
      endcase
    end
  end

  // Compare each accepted span with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_spans.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected span: kind %0d begin %h len %h quirks %b last %b",
                   out_data.span_kind, out_data.span_begin, out_data.span_length,
                   out_data.quirks, out_data.last);
      end else begin
        want = pending_spans.pop_front();
        if (out_data.span_kind != want.span_kind || out_data.span_begin != want.span_begin ||
            out_data.span_length != want.span_length || out_data.quirks != want.quirks ||
            out_data.last != want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("span mismatch: expected kind %0d begin %h len %h quirks %b last %b, %s",
                     want.span_kind, want.span_begin, want.span_length, want.quirks,
                     want.last, $sformatf("got kind %0d begin %h len %h quirks %b last %b",
                     out_data.span_kind, out_data.span_begin, out_data.span_length,
                     out_data.quirks, out_data.last));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_and_wrap();
    test_name_then_end();
    test_public_empty_id();
    test_restart_and_bad_keyword();
    test_drain_pause();
    test_random_tokens();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
